// ===== hdl/ttc_pkg.sv =====
// Shared types and constants for the text terminal cell and cursor engine.
// Holds the datapath command and status types used by the controller and datapath.
// No dependencies.
package ttc_pkg;

	// Port field widths.
	localparam int TEXT_W      = 8;
	localparam int KIND_W      = 2;
	localparam int ROW_W       = 7;
	localparam int COL_W       = 8;
	localparam int GLYPH_W     = 7;
	localparam int OUT_DATA_W  = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int CFG_COLS_W  = 9;
	localparam int CFG_ROWS_W  = 8;

	// Result kinds carried on the output tuser.
	localparam logic [KIND_W-1:0] KIND_CELL   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// Input commands carried on the input tuser.
	localparam logic CMD_TEXT  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;

	// Configuration reset values.
	localparam logic [CFG_COLS_W-1:0] COLS_RESET = 9'd80;
	localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 8'd25;

	// Character codes.
	localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 7'h20;
	localparam logic [TEXT_W-1:0]  CHAR_LF     = 8'h0A;
	localparam logic [TEXT_W-1:0]  CHAR_CR     = 8'h0D;
	localparam logic [TEXT_W-1:0]  CHAR_BS     = 8'h08;
	localparam logic [TEXT_W-1:0]  CHAR_TAB    = 8'h09;
	localparam logic [TEXT_W-1:0]  PRINT_LO    = 8'h20;
	localparam logic [TEXT_W-1:0]  PRINT_HI    = 8'h7E;

	// Tab stops every eight columns.
	localparam int TAB_SHIFT = 3;

	// Commands from the controller to the datapath.
	typedef enum logic [3:0] {
		OP_NONE        = 4'd0,
		OP_INIT_WR     = 4'd1,
		OP_LOAD        = 4'd2,
		OP_CLAMP       = 4'd3,
		OP_CUR_RD      = 4'd4,
		OP_EMIT_OLD    = 4'd5,
		OP_CHAR        = 4'd6,
		OP_WRAP        = 4'd7,
		OP_SCR_RD      = 4'd8,
		OP_SCR_WR      = 4'd9,
		OP_SCR_BLANK   = 4'd10,
		OP_EMIT_SCROLL = 4'd11,
		OP_EMIT_CLEAR  = 4'd12,
		OP_CLR_WR      = 4'd13,
		OP_EMIT_FIN    = 4'd14
	} dp_op_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic cmd_clear;
		logic has_write;
		logic need_scroll;
		logic row_done;
		logic col_last;
		logic row_last;
		logic init_last;
	} dp_status_t;

endpackage

// ===== hdl/ttc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// The read data holds until the next read is issued.
// No dependencies.
module ttc_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/ttc_ctrl.sv =====
// Controller state machine of the text terminal engine.
// Sequences the datapath through each command; depends on ttc_pkg.
module ttc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ttc_pkg::dp_status_t status,
	output ttc_pkg::dp_op_t     op
);

	import ttc_pkg::*;

	typedef enum logic [14:0] {
		S_INIT     = 15'b000000000000001,
		S_IDLE     = 15'b000000000000010,
		S_CLAMP    = 15'b000000000000100,
		S_CUR_RD   = 15'b000000000001000,
		S_CUR_EMIT = 15'b000000000010000,
		S_CHAR     = 15'b000000000100000,
		S_WRAP     = 15'b000000001000000,
		S_SC_RD    = 15'b000000010000000,
		S_SC_WR    = 15'b000000100000000,
		S_SC_BLANK = 15'b000001000000000,
		S_SC_EMIT  = 15'b000010000000000,
		S_CLR_EMIT = 15'b000100000000000,
		S_CLR_FILL = 15'b001000000000000,
		S_FIN_RD   = 15'b010000000000000,
		S_FIN_EMIT = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	// Next state and datapath command.
	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				op = OP_INIT_WR;
				if (status.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_CLAMP;
				end
			end
			S_CLAMP: begin
				op      = OP_CLAMP;
				state_d = status.cmd_clear ? S_CLR_EMIT : S_CUR_RD;
			end
			S_CUR_RD: begin
				op      = OP_CUR_RD;
				state_d = S_CUR_EMIT;
			end
			S_CUR_EMIT: begin
				if (status.out_free) begin
					op      = OP_EMIT_OLD;
					state_d = S_CHAR;
				end
			end
			S_CHAR: begin
				if (!status.has_write || status.out_free) begin
					op      = OP_CHAR;
					state_d = S_WRAP;
				end
			end
			S_WRAP: begin
				op      = OP_WRAP;
				state_d = status.need_scroll ? S_SC_RD : S_FIN_RD;
			end
			S_SC_RD: begin
				if (status.row_done) begin
					state_d = S_SC_BLANK;
				end else begin
					op      = OP_SCR_RD;
					state_d = S_SC_WR;
				end
			end
			S_SC_WR: begin
				op      = OP_SCR_WR;
				state_d = S_SC_RD;
			end
			S_SC_BLANK: begin
				op = OP_SCR_BLANK;
				if (status.col_last) begin
					state_d = S_SC_EMIT;
				end
			end
			S_SC_EMIT: begin
				if (status.out_free) begin
					op      = OP_EMIT_SCROLL;
					state_d = S_FIN_RD;
				end
			end
			S_CLR_EMIT: begin
				if (status.out_free) begin
					op      = OP_EMIT_CLEAR;
					state_d = S_CLR_FILL;
				end
			end
			S_CLR_FILL: begin
				op = OP_CLR_WR;
				if (status.col_last && status.row_last) begin
					state_d = S_FIN_RD;
				end
			end
			S_FIN_RD: begin
				op      = OP_CUR_RD;
				state_d = S_FIN_EMIT;
			end
			S_FIN_EMIT: begin
				if (status.out_free) begin
					op      = OP_EMIT_FIN;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/ttc_datapath.sv =====
// Datapath of the text terminal engine: cursor, sweep counters, config and result register.
// Holds the character store; depends on ttc_pkg and ttc_ram.
module ttc_datapath #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ttc_pkg::dp_op_t                     op,
	output ttc_pkg::dp_status_t                 status,
	input  logic [ttc_pkg::TEXT_W-1:0]          in_text,
	input  logic                                in_cmd,
	input  logic                                cfg_valid,
	input  logic [ttc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ttc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ttc_pkg::KIND_W-1:0]          out_kind,
	output logic [ttc_pkg::ROW_W-1:0]           out_row,
	output logic [ttc_pkg::COL_W-1:0]           out_col,
	output logic [ttc_pkg::GLYPH_W-1:0]         out_glyph,
	output logic                                out_inverse,
	output logic                                out_last
);

	import ttc_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int AW = CW + RW;

	// Configuration and cursor state.
	logic [CFG_COLS_W-1:0] cols_q;
	logic [CFG_ROWS_W-1:0] rows_q;
	logic [CW:0]           cx_q;
	logic [RW:0]           cy_q;
	logic [CW:0]           sc_q;
	logic [RW:0]           sr_q;
	logic [AW-1:0]         init_addr_q;
	logic [TEXT_W-1:0]     text_q;
	logic                  cmd_q;

	// Result register.
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      col_q;
	logic [GLYPH_W-1:0]    glyph_q;
	logic                  inv_q;
	logic                  last_q;

	// Effective screen size.
	logic [CFG_COLS_W-1:0] ecols_full;
	logic [CFG_ROWS_W-1:0] erows_full;
	logic [CW:0]           ecols;
	logic [RW:0]           erows;
	logic [CW:0]           cfg_ecols;
	logic [RW:0]           cfg_erows;

	// Byte handling, wrap and sweep helpers.
	logic [CW:0]           tab_x;
	logic [CW:0]           ch_x;
	logic [RW:0]           ch_y;
	logic                  ch_we;
	logic [CW:0]           ch_wx;
	logic [GLYPH_W-1:0]    ch_glyph;
	logic                  wrap;
	logic [CW:0]           wrap_x;
	logic [RW:0]           wrap_y;
	logic [CW:0]           sc_next;
	logic [RW:0]           sr_next;
	logic [RW:0]           sr_prev;
	logic [RW:0]           erows_m1;
	logic                  col_last;
	logic                  row_last;
	logic                  out_free;

	// Store ports.
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [GLYPH_W-1:0]    ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [GLYPH_W-1:0]    ram_rdata;

	// Emit request.
	logic                  emit;
	logic [KIND_W-1:0]     e_kind;
	logic [ROW_W-1:0]      e_row;
	logic [COL_W-1:0]      e_col;
	logic [GLYPH_W-1:0]    e_glyph;
	logic                  e_inv;
	logic                  e_last;

	// A register of zero acts as one; values above the maximum saturate.
	always_comb begin
		if (cols_q == '0) begin
			ecols_full = CFG_COLS_W'(1);
		end else if (cols_q > CFG_COLS_W'(MAX_COLUMNS)) begin
			ecols_full = CFG_COLS_W'(MAX_COLUMNS);
		end else begin
			ecols_full = cols_q;
		end
		if (rows_q == '0) begin
			erows_full = CFG_ROWS_W'(1);
		end else if (rows_q > CFG_ROWS_W'(MAX_ROWS)) begin
			erows_full = CFG_ROWS_W'(MAX_ROWS);
		end else begin
			erows_full = rows_q;
		end
	end
	assign ecols    = ecols_full[CW:0];
	assign erows    = erows_full[RW:0];
	assign erows_m1 = erows - (RW+1)'(1);

	// Effective size carried by an incoming register write, for the cursor clamp.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_ecols = (CW+1)'(1);
		end else if (cfg_data > CFG_DATA_W'(MAX_COLUMNS)) begin
			cfg_ecols = (CW+1)'(MAX_COLUMNS);
		end else begin
			cfg_ecols = cfg_data[CW:0];
		end
		if (cfg_data[CFG_ROWS_W-1:0] == '0) begin
			cfg_erows = (RW+1)'(1);
		end else if (cfg_data[CFG_ROWS_W-1:0] > CFG_ROWS_W'(MAX_ROWS)) begin
			cfg_erows = (RW+1)'(MAX_ROWS);
		end else begin
			cfg_erows = cfg_data[RW:0];
		end
	end

	// Effect of the latched byte on the cursor and the store.
	assign tab_x = ((cx_q >> TAB_SHIFT) + (CW+1)'(1)) << TAB_SHIFT;
	always_comb begin
		ch_x     = cx_q;
		ch_y     = cy_q;
		ch_we    = 1'b0;
		ch_wx    = cx_q;
		ch_glyph = text_q[GLYPH_W-1:0];
		case (text_q)
			CHAR_LF: begin
				ch_x = '0;
				ch_y = cy_q + (RW+1)'(1);
			end
			CHAR_CR: begin
				ch_x = '0;
			end
			CHAR_BS: begin
				if (cx_q != '0) begin
					ch_x     = cx_q - (CW+1)'(1);
					ch_wx    = cx_q - (CW+1)'(1);
					ch_we    = 1'b1;
					ch_glyph = SPACE_GLYPH;
				end
			end
			CHAR_TAB: begin
				ch_x = tab_x;
			end
			default: begin
				if (text_q >= PRINT_LO && text_q <= PRINT_HI) begin
					ch_we = 1'b1;
					ch_x  = cx_q + (CW+1)'(1);
				end
			end
		endcase
	end

	// Right edge wrap of the updated cursor.
	assign wrap   = (cx_q >= ecols);
	assign wrap_x = wrap ? '0 : cx_q;
	assign wrap_y = wrap ? cy_q + (RW+1)'(1) : cy_q;

	// Sweep counter helpers.
	assign sc_next  = sc_q + (CW+1)'(1);
	assign sr_next  = sr_q + (RW+1)'(1);
	assign sr_prev  = sr_q - (RW+1)'(1);
	assign col_last = (sc_next >= ecols);
	assign row_last = (sr_next >= erows);
	assign out_free = !out_valid_q || out_ready;

	// Command decode: store ports and emit request.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {cy_q[RW-1:0], cx_q[CW-1:0]};
		ram_wdata = SPACE_GLYPH;
		ram_re    = 1'b0;
		ram_raddr = {cy_q[RW-1:0], cx_q[CW-1:0]};
		emit      = 1'b0;
		e_kind    = KIND_CELL;
		e_row     = ROW_W'(cy_q[RW-1:0]);
		e_col     = COL_W'(cx_q[CW-1:0]);
		e_glyph   = ram_rdata;
		e_inv     = 1'b0;
		e_last    = 1'b0;
		unique case (op)
			OP_NONE, OP_LOAD, OP_CLAMP, OP_WRAP: begin
			end
			OP_INIT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = init_addr_q;
			end
			OP_CUR_RD: begin
				ram_re = 1'b1;
			end
			OP_EMIT_OLD: begin
				emit = 1'b1;
			end
			OP_CHAR: begin
				ram_we    = ch_we;
				ram_waddr = {cy_q[RW-1:0], ch_wx[CW-1:0]};
				ram_wdata = ch_glyph;
				emit      = ch_we;
				e_col     = COL_W'(ch_wx[CW-1:0]);
				e_glyph   = ch_glyph;
			end
			OP_SCR_RD: begin
				ram_re    = 1'b1;
				ram_raddr = {sr_q[RW-1:0], sc_q[CW-1:0]};
			end
			OP_SCR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {sr_prev[RW-1:0], sc_q[CW-1:0]};
				ram_wdata = ram_rdata;
			end
			OP_SCR_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = {erows_m1[RW-1:0], sc_q[CW-1:0]};
			end
			OP_EMIT_SCROLL: begin
				emit    = 1'b1;
				e_kind  = KIND_SCROLL;
				e_row   = '0;
				e_col   = '0;
				e_glyph = '0;
			end
			OP_EMIT_CLEAR: begin
				emit    = 1'b1;
				e_kind  = KIND_CLEAR;
				e_row   = '0;
				e_col   = '0;
				e_glyph = '0;
			end
			OP_CLR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {sr_q[RW-1:0], sc_q[CW-1:0]};
			end
			OP_EMIT_FIN: begin
				emit   = 1'b1;
				e_inv  = 1'b1;
				e_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Character store.
	ttc_ram #(
		.WIDTH(GLYPH_W),
		.DEPTH(1 << AW)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COLUMNS: cols_q <= cfg_data;
				CFG_ROWS:    rows_q <= cfg_data[CFG_ROWS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Cursor, sweep counters and reset fill address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q        <= '0;
			cy_q        <= '0;
			sc_q        <= '0;
			sr_q        <= '0;
			init_addr_q <= '0;
		end else begin
			case (op)
				OP_INIT_WR: begin
					init_addr_q <= init_addr_q + AW'(1);
				end
				OP_CLAMP: begin
					if (cx_q >= ecols) begin
						cx_q <= ecols - (CW+1)'(1);
					end
					if (cy_q >= erows) begin
						cy_q <= erows_m1;
					end
				end
				OP_CHAR: begin
					cx_q <= ch_x;
					cy_q <= ch_y;
				end
				OP_WRAP: begin
					cx_q <= wrap_x;
					cy_q <= wrap_y;
					sr_q <= (RW+1)'(1);
					sc_q <= '0;
				end
				OP_SCR_WR, OP_CLR_WR: begin
					if (col_last) begin
						sc_q <= '0;
						sr_q <= sr_next;
					end else begin
						sc_q <= sc_next;
					end
				end
				OP_SCR_BLANK: begin
					sc_q <= sc_next;
				end
				OP_EMIT_SCROLL: begin
					cy_q <= erows_m1;
				end
				OP_EMIT_CLEAR: begin
					cx_q <= '0;
					cy_q <= '0;
					sr_q <= '0;
					sc_q <= '0;
				end
				default: begin
					// Register writes arrive only between items; a smaller screen
					// pulls the cursor to its last column or row.
					if (cfg_valid && cfg_index == CFG_COLUMNS && cx_q >= cfg_ecols) begin
						cx_q <= cfg_ecols - (CW+1)'(1);
					end
					if (cfg_valid && cfg_index == CFG_ROWS && cy_q >= cfg_erows) begin
						cy_q <= cfg_erows - (RW+1)'(1);
					end
				end
			endcase
		end
	end

	// Input item latch.
	always_ff @(posedge clk) begin
		if (op == OP_LOAD) begin
			text_q <= in_text;
			cmd_q  <= in_cmd;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= e_kind;
			row_q   <= e_row;
			col_q   <= e_col;
			glyph_q <= e_glyph;
			inv_q   <= e_inv;
			last_q  <= e_last;
		end
	end

	// Status to the controller.
	assign status.out_free    = out_free;
	assign status.cmd_clear   = (cmd_q == CMD_CLEAR);
	assign status.has_write   = ch_we;
	assign status.need_scroll = (wrap_y >= erows);
	assign status.row_done    = (sr_q >= erows);
	assign status.col_last    = col_last;
	assign status.row_last    = row_last;
	assign status.init_last   = &init_addr_q;

	assign out_valid   = out_valid_q;
	assign out_kind    = kind_q;
	assign out_row     = row_q;
	assign out_col     = col_q;
	assign out_glyph   = glyph_q;
	assign out_inverse = inv_q;
	assign out_last    = last_q;

endmodule

// ===== hdl/text_terminal_cell_cursor_engine.sv =====
// Top level of the text terminal cell and cursor engine.
// Joins the controller (ttc_ctrl) and the datapath (ttc_datapath); depends on ttc_pkg.
//
// The engine takes one item at a time: a text byte or a clear command. After reset it
// runs a clearing pass over the character store, one cell a cycle, and takes no item
// until that is done. A text byte takes a store read and a normal redraw of the old
// cursor cell, one write and result for a printable character or backspace, a wrap
// check, and a store read and the inverted cursor cell. A scroll copies each cell of
// the lower rows up one row with one read and one write, blanks the bottom row and
// emits a scroll result. A clear emits its result, then fills every cell of the screen.
// A finished result waits in an output register, so the next item is taken while the
// last result is still pending. Configuration writes are taken only while the engine
// waits for an item (cfg_ready follows s_tready); a write that shrinks the screen
// pulls the cursor inside it.
module text_terminal_cell_cursor_engine #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input items.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ttc_pkg::TEXT_W-1:0]          s_tdata,   // [7:0] text_byte
	input  logic [0:0]                          s_tuser,   // [0] command
	// Result items.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ttc_pkg::OUT_DATA_W-1:0]      m_tdata,   // [6:0] cell_row, [14:7] cell_col,
	                                                       // [21:15] glyph_code, [22] inverse
	output logic [ttc_pkg::KIND_W-1:0]          m_tuser,   // [1:0] kind
	output logic                                m_tlast,   // last_of_run
	// Configuration writes.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ttc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ttc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import ttc_pkg::*;

	dp_op_t             op;
	dp_status_t         status;
	logic [ROW_W-1:0]   out_row;
	logic [COL_W-1:0]   out_col;
	logic [GLYPH_W-1:0] out_glyph;
	logic               out_inverse;

	// Configuration writes are taken only between items.
	assign cfg_ready = s_tready;

	// Sequencer.
	ttc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.status  (status),
		.op      (op)
	);

	// Cursor, store and result register.
	ttc_datapath #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.status     (status),
		.in_text    (s_tdata),
		.in_cmd     (s_tuser[0]),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_glyph  (out_glyph),
		.out_inverse(out_inverse),
		.out_last   (m_tlast)
	);

	// Pack the result fields, lowest field first, padded to whole bytes.
	assign m_tdata = {1'b0, out_inverse, out_glyph, out_col, out_row};

endmodule

// ===== hdl/ttc_checker.sv =====
// Port-level checks for the text terminal engine, bound to the top level.
// Depends on ttc_pkg and text_terminal_cell_cursor_engine.
module ttc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ttc_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [ttc_pkg::KIND_W-1:0]      m_tuser,
	input logic                            m_tlast,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);

	import ttc_pkg::*;

	// A pending result stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed or dropped while stalled");

	// Items are taken one at a time: no input transaction right after another.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on two consecutive cycles");

	// Scroll and clear results carry zero fields and never end a run.
	a_bulk_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_CELL |-> m_tdata == '0 && !m_tlast)
		else $error("scroll or clear result with nonzero fields or run end");

	// Only the final cursor draw of a run is inverted.
	a_inverse_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_CELL |-> m_tdata[22] == m_tlast)
		else $error("inverse flag does not match run end");

	// A configuration transaction happens only while the engine waits for an item.
	a_cfg_between_items: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> s_tready)
		else $error("configuration accepted while an item is in flight");

endmodule

bind text_terminal_cell_cursor_engine ttc_checker u_ttc_checker (.*);

// ===== test/text_terminal_cell_cursor_engine_test.sv =====
// Self-checking testbench for the text terminal cell and cursor engine.
// Holds its own model of the character grid and cursor and checks every result transaction.
// Depends on ttc_pkg and text_terminal_cell_cursor_engine.
module text_terminal_cell_cursor_engine_test;
	import ttc_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int COLS_MAX       = 256;
	localparam int ROWS_MAX       = 128;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_SETTLE     = 32;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int HOLD_OFF_LEN   = 400;

	// Register indexes that the block does not decode.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_3 = 2'd3;

	// One display update as the block should report it.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [GLYPH_W-1:0] glyph;
		logic               inv;
		logic               last;
	} screen_update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TEXT_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = CMD_TEXT;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Model state: character grid, cursor and screen size registers.
	logic [GLYPH_W-1:0] screen_chars [ROWS_MAX*COLS_MAX];
	logic [CFG_COLS_W-1:0] columns_reg = COLS_RESET;
	logic [CFG_ROWS_W-1:0] rows_reg = ROWS_RESET;
	int unsigned cursor_x = 0;
	int unsigned cursor_y = 0;
	screen_update_t pending_updates[$];

	int mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned sink_hold_cycles = 0;
	bit feed_gaps_on = 1'b1;
	bit drain_gaps_on = 1'b1;

	text_terminal_cell_cursor_engine #(
		.MAX_COLUMNS(COLS_MAX),
		.MAX_ROWS(ROWS_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Effective screen size: zero acts as one, large values saturate.
	function automatic int unsigned active_columns();
		if (columns_reg == 0) return 1;
		if (columns_reg > COLS_MAX) return COLS_MAX;
		return columns_reg;
	endfunction

	function automatic int unsigned active_rows();
		if (rows_reg == 0) return 1;
		if (rows_reg > ROWS_MAX) return ROWS_MAX;
		return rows_reg;
	endfunction

	function automatic int unsigned spot(input int unsigned y, input int unsigned x);
		return (y % ROWS_MAX) * COLS_MAX + (x % COLS_MAX);
	endfunction

	function automatic void clamp_cursor();
		if (cursor_x >= active_columns()) cursor_x = active_columns() - 1;
		if (cursor_y >= active_rows()) cursor_y = active_rows() - 1;
	endfunction

	function automatic void push_update(input logic [KIND_W-1:0] kind, input int unsigned y,
		input int unsigned x, input logic [GLYPH_W-1:0] glyph, input logic inv,
		input logic last);
		screen_update_t u;
		u.kind = kind;
		u.row = ROW_W'(y);
		u.col = COL_W'(x);
		u.glyph = glyph;
		u.inv = inv;
		u.last = last;
		pending_updates.push_back(u);
	endfunction

	// The inverted cursor cell always closes the run of an item.
	function automatic void push_cursor(input logic inv);
		push_update(KIND_CELL, cursor_y, cursor_x, screen_chars[spot(cursor_y, cursor_x)],
			inv, inv);
	endfunction

	// Register writes resize the screen and pull the cursor inside it.
	function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		if (idx == CFG_COLUMNS) begin
			columns_reg = value;
			clamp_cursor();
		end else if (idx == CFG_ROWS) begin
			rows_reg = value[CFG_ROWS_W-1:0];
			clamp_cursor();
		end
	endfunction

	// Work out the display updates that one accepted item causes.
	function automatic void predict_updates(input logic cmd, input logic [TEXT_W-1:0] ch);
		int unsigned cols, rows, x, y;
		cols = active_columns();
		rows = active_rows();
		clamp_cursor();
		if (cmd == CMD_CLEAR) begin
			for (int r = 0; r < rows; r++)
				for (int c = 0; c < cols; c++)
					screen_chars[spot(r, c)] = SPACE_GLYPH;
			push_update(KIND_CLEAR, 0, 0, '0, 1'b0, 1'b0);
			cursor_x = 0;
			cursor_y = 0;
		end else begin
			push_cursor(1'b0);
			x = cursor_x;
			y = cursor_y;
			if (ch == CHAR_LF) begin
				x = 0;
				y++;
			end else if (ch == CHAR_CR) begin
				x = 0;
			end else if (ch == CHAR_BS) begin
				// Backspace at the left edge does nothing.
				if (x > 0) begin
					x--;
					screen_chars[spot(y, x)] = SPACE_GLYPH;
					push_update(KIND_CELL, y, x, SPACE_GLYPH, 1'b0, 1'b0);
				end
			end else if (ch == CHAR_TAB) begin
				x = ((x >> TAB_SHIFT) + 1) << TAB_SHIFT;
			end else if (ch >= PRINT_LO && ch <= PRINT_HI) begin
				screen_chars[spot(y, x)] = ch[GLYPH_W-1:0];
				push_update(KIND_CELL, y, x, ch[GLYPH_W-1:0], 1'b0, 1'b0);
				x++;
			end
			// Wrap at the right edge, then scroll when past the bottom row.
			if (x >= cols) begin
				x = 0;
				y++;
			end
			if (y >= rows) begin
				for (int r = 1; r < rows; r++)
					for (int c = 0; c < cols; c++)
						screen_chars[spot(r - 1, c)] = screen_chars[spot(r, c)];
				for (int c = 0; c < cols; c++)
					screen_chars[spot(rows - 1, c)] = SPACE_GLYPH;
				push_update(KIND_SCROLL, 0, 0, '0, 1'b0, 1'b0);
				y = rows - 1;
			end
			cursor_x = x;
			cursor_y = y;
		end
		push_cursor(1'b1);
	endfunction

	function automatic void check_field(input string field_name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
			mismatch_count++;
		end
	endfunction

	// Mostly printable text with a fair share of control and ignored bytes.
	function automatic logic [TEXT_W-1:0] pick_text_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return TEXT_W'($urandom_range(PRINT_LO, PRINT_HI));
		if (r < 68) return CHAR_LF;
		if (r < 73) return CHAR_CR;
		if (r < 80) return CHAR_BS;
		if (r < 86) return CHAR_TAB;
		return TEXT_W'($urandom_range(0, 255));
	endfunction

	// Offer one item after a random gap. The valid stays high on return, so the
	// caller either sends the next item at once or lowers it by waiting for idle.
	task automatic send_item(input logic cmd, input logic [TEXT_W-1:0] ch);
		int unsigned gap, r;
		gap = 0;
		if (feed_gaps_on) begin
			r = $urandom_range(0, 99);
			if (r >= 85) gap = $urandom_range(8, 30);
			else if (r >= 50) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tuser <= cmd;
		predict_updates(cmd, ch);
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering items and wait until every expected result has come.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value, input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, value);
		if (!more) cfg_valid <= 1'b0;
	endtask

	task automatic set_screen(input logic [CFG_DATA_W-1:0] cols,
		input logic [CFG_DATA_W-1:0] rows);
		wait_idle();
		write_register(CFG_COLUMNS, cols, 1'b1);
		write_register(CFG_ROWS, rows, 1'b0);
	endtask

	// Every byte class at the reset screen size, then clears.
	task automatic test_text_bytes();
		send_item(CMD_TEXT, "A");
		send_item(CMD_TEXT, PRINT_HI);
		send_item(CMD_TEXT, PRINT_LO);
		send_item(CMD_TEXT, CHAR_BS);
		send_item(CMD_TEXT, CHAR_TAB);
		send_item(CMD_TEXT, CHAR_CR);
		send_item(CMD_TEXT, CHAR_BS);
		send_item(CMD_TEXT, CHAR_LF);
		// Bytes below and above the printable range are ignored.
		send_item(CMD_TEXT, 8'h00);
		send_item(CMD_TEXT, 8'h1F);
		send_item(CMD_TEXT, 8'h7F);
		send_item(CMD_TEXT, 8'h80);
		send_item(CMD_TEXT, 8'hFF);
		send_item(CMD_CLEAR, 8'hFF);
		send_item(CMD_TEXT, "z");
		send_item(CMD_CLEAR, 8'h00);
	endtask

	// Wrap at the right edge and scroll at the bottom on an 8 by 2 screen.
	task automatic test_screen_edges();
		set_screen(9'd8, 9'd2);
		for (int i = 0; i < 8; i++) send_item(CMD_TEXT, 8'h30 + 8'(i));
		send_item(CMD_TEXT, "a");
		send_item(CMD_TEXT, CHAR_TAB);
		for (int i = 0; i < 8; i++) send_item(CMD_TEXT, 8'h62 + 8'(i));
		send_item(CMD_TEXT, CHAR_LF);
		send_item(CMD_TEXT, CHAR_BS);
		send_item(CMD_TEXT, "j");
		send_item(CMD_TEXT, "k");
		send_item(CMD_TEXT, CHAR_BS);
	endtask

	// Register extremes, unknown indexes, cursor clamping and the largest screen.
	task automatic test_register_limits();
		// Zero acts as one, which also pulls the cursor to the corner.
		set_screen(9'd0, 9'd0);
		send_item(CMD_TEXT, "x");
		send_item(CMD_TEXT, CHAR_LF);
		send_item(CMD_TEXT, CHAR_BS);
		send_item(CMD_TEXT, CHAR_TAB);
		send_item(CMD_TEXT, 8'h80);
		wait_idle();
		write_register(CFG_UNUSED_2, 9'h1FF, 1'b1);
		write_register(CFG_UNUSED_3, 9'h000, 1'b1);
		write_register(CFG_COLUMNS, 9'h1FF, 1'b1);
		write_register(CFG_ROWS, 9'h1FF, 1'b0);
		// Walk down to the last row, then tab off the right edge to scroll.
		for (int i = 0; i < ROWS_MAX - 1; i++) send_item(CMD_TEXT, CHAR_LF);
		for (int i = 0; i < (COLS_MAX >> TAB_SHIFT); i++) send_item(CMD_TEXT, CHAR_TAB);
		send_item(CMD_TEXT, "m");
		send_item(CMD_CLEAR, 8'h5A);
		// Just above the maximum saturates too.
		set_screen(9'd257, 9'd129);
		send_item(CMD_TEXT, "e");
		send_item(CMD_TEXT, CHAR_BS);
	endtask

	// The receiver holds off while items keep coming, so the input stalls.
	task automatic test_backpressure();
		set_screen(9'd16, 9'd4);
		feed_gaps_on = 1'b0;
		sink_hold_cycles = HOLD_OFF_LEN;
		for (int i = 0; i < 30; i++) send_item(CMD_TEXT, pick_text_byte());
		wait_idle();
		feed_gaps_on = 1'b1;
	endtask

	// Random text in phases of different screen sizes.
	task automatic test_random_text();
		for (int phase = 0; phase < 7; phase++) begin
			if (phase == 0)
				set_screen(CFG_DATA_W'(COLS_RESET), CFG_DATA_W'(ROWS_RESET));
			else
				set_screen(CFG_DATA_W'($urandom_range(1, 24)),
					CFG_DATA_W'($urandom_range(1, 6)));
			// One phase runs without gaps on either side.
			feed_gaps_on = (phase != 2);
			drain_gaps_on = (phase != 2);
			for (int i = 0; i < 33; i++) begin
				if ($urandom_range(0, 99) < 3) wait_idle();
				if ($urandom_range(0, 99) < 3)
					send_item(CMD_CLEAR, TEXT_W'($urandom));
				else
					send_item(CMD_TEXT, pick_text_byte());
			end
		end
		feed_gaps_on = 1'b1;
		drain_gaps_on = 1'b1;
	endtask

	// Main sequence.
	initial begin
		for (int i = 0; i < ROWS_MAX * COLS_MAX; i++) screen_chars[i] = SPACE_GLYPH;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_text_bytes();
		test_screen_edges();
		test_register_limits();
		test_backpressure();
		test_random_text();
		wait_idle();
		repeat (END_SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("text_terminal_cell_cursor_engine regression: pass");
		else
			$display("text_terminal_cell_cursor_engine regression: fail");
		$finish;
	end

	// Result receiver: random stalls, plus a long hold-off when requested.
	initial begin : result_sink
		int unsigned stall_left, r;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold_cycles) @(posedge clk);
				sink_hold_cycles = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (drain_gaps_on && $urandom_range(0, 99) < 25) begin
				r = $urandom_range(0, 99);
				if (r < 60) stall_left = 0;
				else if (r < 92) stall_left = $urandom_range(1, 3);
				else stall_left = $urandom_range(10, 40);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest expected update.
	always @(posedge clk) begin : result_check
		screen_update_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_updates.size() == 0) begin
				$error("unexpected result: kind 0x%0h, data 0x%0h", m_tuser, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_updates.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("cell_row", want.row, m_tdata[6:0]);
				check_field("cell_col", want.col, m_tdata[14:7]);
				check_field("glyph_code", want.glyph, m_tdata[21:15]);
				check_field("inverse", want.inv, m_tdata[22]);
				check_field("last_of_run", want.last, m_tlast);
			end
		end
	end

	// End the run when no transaction of any kind happens for too long.
	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("text_terminal_cell_cursor_engine regression: fail");
				$finish;
			end
		end
	end

endmodule
